>>> hdl/fixed_float32_converter_top_macros.svh
// Assertion macros shared by the converter RTL.
// Expects clock aclk and active-low reset aresetn in the including scope.
`ifndef FIXED_FLOAT32_CONVERTER_TOP_MACROS_SVH
`define FIXED_FLOAT32_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, skipped while in reset
`define FXF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while in reset
`define FXF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fxf_pkg.sv
// Package for the fixed/float32 converter: commands, constants, stage payloads.
// No dependencies; imported by every converter module.
`timescale 1ns / 1ps
`default_nettype none

package fxf_pkg;

    // command codes carried on s_tuser
    typedef enum logic {
        CMD_FIX2FLT = 1'b0,
        CMD_FLT2FIX = 1'b1
    } fxf_cmd_t;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned FRAC_W = 5;
    localparam int unsigned MSB_W  = 5;

    localparam logic [7:0]        EXP_BIAS     = 8'd127;
    // biased exponent whose significand needs no shift to land in Q16.16
    localparam logic [7:0]        Q16_EXP_ZERO = 8'd134;
    // above this the magnitude no longer fits in 31 bits
    localparam logic [7:0]        Q16_EXP_MAX  = 8'd141;
    // at or below this the right shift is 32 or more
    localparam logic [7:0]        Q16_EXP_TINY = 8'd102;
    localparam logic [WORD_W-1:0] HIDDEN_ONE   = 32'h0080_0000;
    localparam logic [WORD_W-1:0] MANT_MASK    = 32'h007F_FFFF;
    localparam logic [WORD_W-1:0] SAT_MAG      = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_NEG      = 32'h8000_0001;

    // after decode
    typedef struct packed {
        fxf_cmd_t          cmd;
        logic              neg;
        logic [WORD_W-1:0] mag;
        logic [FRAC_W-1:0] frac;
        logic              zero;
        logic              sat;
        logic              left;
        logic [2:0]        lsh;
        logic [4:0]        rsh;
    } fxf_s1_t;

    // after leading-one search / rounding add
    typedef struct packed {
        fxf_cmd_t          cmd;
        logic              neg;
        logic [WORD_W-1:0] val;
        logic [MSB_W-1:0]  msb;
        logic [FRAC_W-1:0] frac;
        logic              zero;
        logic              sat;
        logic              left;
        logic [4:0]        rsh;
    } fxf_s2_t;

    // final result word
    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic              saturated;
    } fxf_s3_t;

    // index of the highest set bit, 0 for a zero word
    function automatic logic [MSB_W-1:0] lead_one(input logic [WORD_W-1:0] v);
        logic [MSB_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                pos = MSB_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

>>> hdl/fxf_decode.sv
// Stage 1: splits the input word, takes the fixed magnitude, classifies floats.
// Depends on fxf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fxf_decode (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire fxf_pkg::fxf_cmd_t  in_cmd,
    input  wire logic [31:0]        in_operand,
    input  wire logic [4:0]         in_frac,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output fxf_pkg::fxf_s1_t        out_data
);
    import fxf_pkg::*;

    logic       valid_reg;
    fxf_s1_t    data_reg;
    fxf_s1_t    data_next;
    logic [7:0] ex;
    logic [7:0] ex_up;
    logic [7:0] ex_down;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign ex      = in_operand[30:23];
    assign ex_up   = ex - Q16_EXP_ZERO;
    assign ex_down = Q16_EXP_ZERO - ex;

    // decode one word
    always_comb begin
        data_next      = '0;
        data_next.cmd  = in_cmd;
        data_next.neg  = in_operand[31];
        data_next.frac = in_frac;
        if (in_cmd == CMD_FIX2FLT) begin
            data_next.mag  = in_operand[31] ? (~in_operand + 32'd1) : in_operand;
            data_next.zero = (in_operand == '0);
        end else begin
            data_next.mag  = HIDDEN_ONE | (in_operand & MANT_MASK);
            data_next.zero = (ex == 8'd0) || (ex <= Q16_EXP_TINY);
            data_next.sat  = (ex > Q16_EXP_MAX);
            data_next.left = (ex >= Q16_EXP_ZERO);
            data_next.lsh  = ex_up[2:0];
            data_next.rsh  = ex_down[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fxf_align.sv
// Stage 2: leading-one search for fixed input; rounding add or left shift for floats.
// Depends on fxf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fxf_align (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire fxf_pkg::fxf_s1_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output fxf_pkg::fxf_s2_t        out_data
);
    import fxf_pkg::*;

    logic    valid_reg;
    fxf_s2_t data_reg;
    fxf_s2_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next      = '0;
        data_next.cmd  = in_data.cmd;
        data_next.neg  = in_data.neg;
        data_next.frac = in_data.frac;
        data_next.zero = in_data.zero;
        data_next.sat  = in_data.sat;
        data_next.left = in_data.left;
        data_next.rsh  = in_data.rsh;
        data_next.msb  = lead_one(in_data.mag);
        if (in_data.cmd == CMD_FIX2FLT) begin
            data_next.val = in_data.mag;
        end else if (in_data.left) begin
            data_next.val = in_data.mag << in_data.lsh;
        end else begin
            // add half an output LSB before the right shift
            data_next.val = in_data.mag + (32'd1 << (in_data.rsh - 5'd1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fxf_pack.sv
// Stage 3: normalizes and packs float32, or shifts, clamps and signs Q16.16.
// Depends on fxf_pkg; its register is the output register of the block.
`timescale 1ns / 1ps
`default_nettype none

module fxf_pack (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire fxf_pkg::fxf_s2_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output fxf_pkg::fxf_s3_t        out_data
);
    import fxf_pkg::*;

    logic        valid_reg;
    fxf_s3_t     data_reg;
    fxf_s3_t     data_next;
    logic [31:0] norm;
    logic [7:0]  expo;
    logic [31:0] mag;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // fixed path: leading one to bit 31, exponent from its position
    assign norm = in_data.val << (~in_data.msb);
    assign expo = {3'b000, in_data.msb} + EXP_BIAS - {3'b000, in_data.frac};

    // float path magnitude
    always_comb begin
        if (in_data.sat) begin
            mag = SAT_MAG;
        end else if (in_data.zero) begin
            mag = '0;
        end else if (in_data.left) begin
            mag = in_data.val;
        end else begin
            mag = in_data.val >> in_data.rsh;
        end
    end

    always_comb begin
        data_next = '0;
        if (in_data.cmd == CMD_FIX2FLT) begin
            if (!in_data.zero) begin
                data_next.result_word = {in_data.neg, expo, norm[30:8]};
            end
        end else begin
            data_next.result_word = in_data.neg ? (~mag + 32'd1) : mag;
            data_next.saturated   = in_data.sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fixed_float32_converter_top.sv
// Top level of the fixed-point / float32 converter: three pipeline stages.
// Depends on fxf_pkg, fxf_decode, fxf_align, fxf_pack and the macros header.
//
// Usage:
//   Input stream s_*: s_tuser selects the command (0 fixed to float32 bits,
//   1 float32 bits to Q16.16); s_tdata carries the operand and, for command 0,
//   the count of fraction bits. Output stream m_*: one word per input word,
//   in order; m_tdata is the result, m_tuser flags a clamped Q16.16 value.
//   Pipeline: three register stages; a word passes decode, align and pack
//   in that order and leaves from the pack register.
//   Throughput: one word per cycle while m_tready stays high; each of the
//   three stages holds one word. The depth is set by the decode /
//   leading-one + rounding add / normalize-shift + negate stages.
//   Stall: a stage with a word waiting keeps it until the next stage frees up;
//   empty stages keep filling, so s_tready drops only once all three are full.
//   Reset (aresetn low, synchronous) empties all stages; no word is lost or
//   duplicated across a stall.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_float32_converter_top_macros.svh"

module fixed_float32_converter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] operand, [36:32] fraction_bits, zero pad
    input  wire logic [0:0]  s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] result_word
    output logic [0:0]       m_tuser    // [0] saturated
);
    import fxf_pkg::*;

    logic     s1_valid;
    logic     s2_valid;
    logic     s2_ready;
    logic     s3_ready;
    fxf_s1_t  s1_data;
    fxf_s2_t  s2_data;
    fxf_s3_t  s3_data;
    fxf_cmd_t in_cmd;

    assign in_cmd = fxf_cmd_t'(s_tuser[0]);

    fxf_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (in_cmd),
        .in_operand (s_tdata[31:0]),
        .in_frac    (s_tdata[36:32]),
        .out_valid  (s1_valid),
        .out_ready  (s2_ready),
        .out_data   (s1_data)
    );

    fxf_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s2_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s3_ready),
        .out_data  (s2_data)
    );

    fxf_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s3_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (s3_data)
    );

    assign m_tdata    = s3_data.result_word;
    assign m_tuser[0] = s3_data.saturated;

    // a clamped result is always one of the two saturation words
    `FXF_ASSERT_IMP(a_sat_word, m_tvalid && m_tuser[0], m_tdata == SAT_MAG || m_tdata == SAT_NEG, "saturated flag with a non-clamped word")

    // an open output side never blocks the input side
    `FXF_ASSERT_IMP(a_no_block, m_tready, s_tready, "input stalled while output is ready")

    // a word waiting in stage 2 is kept unchanged while stage 3 is blocked
    `FXF_ASSERT_NEXT(a_s2_hold, s2_valid && !s3_ready, s2_valid && $stable(s2_data), "stage 2 word lost during stall")

endmodule

`default_nettype wire

>>> bench/tb_fixed_float32_converter_top.sv
`timescale 1ns / 1ps
// Self-checking bench for fixed_float32_converter_top: directed edge values,
// then random traffic, each result checked against an in-bench conversion model.
// Depends on fxf_pkg and the converter RTL only.

module tb_fixed_float32_converter_top;
    import fxf_pkg::*;

    // one predicted output word, plus the input that caused it for reports
    typedef struct packed {
        fxf_cmd_t    cmd;
        logic [31:0] operand;
        logic [4:0]  frac;
        logic [31:0] word;
        logic        sat;
    } conversion_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;     // [31:0] operand, [36:32] fraction_bits, zero pad
    logic [0:0]  s_tuser  = '0;     // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] result_word
    logic [0:0]  m_tuser;           // [0] saturated

    conversion_t expected_conversions[$];
    bit          no_idle       = 1'b0;
    int          fail_count    = 0;
    int          words_checked = 0;
    int          fix_sent      = 0;
    int          flt_sent      = 0;
    int          sat_seen      = 0;

    fixed_float32_converter_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("fixed_float32_converter_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // conversion model
    // ------------------------------------------------------------------

    // fixed value with frac fraction bits -> float32 bits, truncating
    function automatic logic [31:0] float_from_fixed(input logic [31:0] value,
                                                     input logic [4:0] frac);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] mant;
        logic [7:0]  expo;
        int          msb;
        neg = value[31];
        mag = neg ? (~value + 32'd1) : value;
        if (mag == '0) begin
            return '0;
        end
        msb = 0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) begin
                msb = i;
            end
        end
        expo = 8'(msb) + EXP_BIAS - 8'(frac);
        if (msb <= 23) begin
            mant = mag << (23 - msb);
        end else begin
            mant = mag >> (msb - 23);
        end
        return {neg, expo, mant[22:0]};
    endfunction

    // float32 bits -> Q16.16 with round half away from zero, flush and saturation
    function automatic logic [31:0] q16_from_float(input logic [31:0] bits,
                                                   output logic sat);
        logic [7:0]  ex;
        logic [31:0] sig;
        logic [31:0] mag;
        int          rs;
        ex  = bits[30:23];
        sat = 1'b0;
        if (ex == 8'd0) begin
            return '0;
        end
        sig = HIDDEN_ONE | (bits & MANT_MASK);
        if (ex >= Q16_EXP_ZERO) begin
            if (ex > Q16_EXP_MAX) begin
                mag = SAT_MAG;
                sat = 1'b1;
            end else begin
                mag = sig << (ex - Q16_EXP_ZERO);
            end
        end else begin
            rs = int'(Q16_EXP_ZERO) - int'(ex);
            if (rs >= 32) begin
                mag = '0;
            end else begin
                mag = (sig + (32'd1 << (rs - 1))) >> rs;
            end
        end
        return bits[31] ? (~mag + 32'd1) : mag;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // drive one word, wait for the handshake, then queue its prediction
    task automatic send_word(input fxf_cmd_t cmd, input logic [31:0] operand,
                             input logic [4:0] frac);
        conversion_t c;
        c.cmd     = cmd;
        c.operand = operand;
        c.frac    = frac;
        c.sat     = 1'b0;
        if (cmd == CMD_FIX2FLT) begin
            c.word = float_from_fixed(operand, frac);
            fix_sent++;
        end else begin
            c.word = q16_from_float(operand, c.sat);
            flt_sent++;
        end
        while (!no_idle && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, frac, operand};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        expected_conversions.push_back(c);
    endtask

    function automatic logic [31:0] random_fixed();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(9) != 0) begin
            v = v >> $urandom_range(31);
            if ($urandom_range(1) != 0) begin
                v = ~v + 32'd1;
            end
        end
        return v;
    endfunction

    function automatic logic [4:0] random_frac();
        if ($urandom_range(9) == 0) begin
            return 5'($urandom_range(31));
        end
        return 5'($urandom_range(16));
    endfunction

    // exponents weighted around the Q16.16 window and its edges
    function automatic logic [31:0] random_float();
        logic [7:0]  ex;
        logic [22:0] mant;
        int          pick;
        pick = $urandom_range(99);
        mant = 23'($urandom);
        if (pick < 70) begin
            ex = 8'($urandom_range(150, 95));
        end else if (pick < 80) begin
            ex = 8'd0;
        end else if (pick < 85) begin
            ex = 8'hFF;
        end else begin
            ex = 8'($urandom_range(255));
        end
        if ($urandom_range(19) == 0) begin
            mant = '0;
        end
        return {1'($urandom_range(1)), ex, mant};
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1) != 0) begin
                send_word(CMD_FLT2FIX, random_float(), random_frac());
            end else begin
                send_word(CMD_FIX2FLT, random_fixed(), random_frac());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero, unit, extremes of both sign and fraction count, truncation
    task automatic test_fixed_edges();
        send_word(CMD_FIX2FLT, 32'h0000_0000, 5'd0);
        send_word(CMD_FIX2FLT, 32'h0000_0001, 5'd0);
        send_word(CMD_FIX2FLT, 32'hFFFF_FFFF, 5'd16);
        send_word(CMD_FIX2FLT, 32'h7FFF_FFFF, 5'd0);
        send_word(CMD_FIX2FLT, 32'h8000_0000, 5'd0);
        send_word(CMD_FIX2FLT, 32'h8000_0000, 5'd16);
        send_word(CMD_FIX2FLT, 32'h0001_0000, 5'd16);
        send_word(CMD_FIX2FLT, 32'h00FF_FFFF, 5'd8);
        send_word(CMD_FIX2FLT, 32'h01FF_FFFF, 5'd3);
        // fraction counts past the nominal range
        send_word(CMD_FIX2FLT, 32'h0000_0001, 5'd31);
        send_word(CMD_FIX2FLT, 32'h8000_0000, 5'd17);
    endtask

    // zeros, subnormals, rounding, flush, saturation, inf and NaN
    task automatic test_float_edges();
        send_word(CMD_FLT2FIX, 32'h0000_0000, 5'd0);
        send_word(CMD_FLT2FIX, 32'h8000_0000, 5'd0);
        send_word(CMD_FLT2FIX, 32'h0000_0001, 5'd0);
        send_word(CMD_FLT2FIX, 32'h807F_FFFF, 5'd0);
        send_word(CMD_FLT2FIX, 32'h3F80_0000, 5'd0);
        send_word(CMD_FLT2FIX, 32'hBF80_0000, 5'd0);
        send_word(CMD_FLT2FIX, 32'h3700_0000, 5'd0);   // half an lsb rounds up
        send_word(CMD_FLT2FIX, {1'b0, Q16_EXP_TINY, 23'h7F_FFFF}, 5'd0);
        send_word(CMD_FLT2FIX, {1'b0, 8'd103, 23'h00_0000}, 5'd0);
        send_word(CMD_FLT2FIX, {1'b0, Q16_EXP_ZERO, 23'h12_3456}, 5'd0);
        send_word(CMD_FLT2FIX, {1'b1, Q16_EXP_MAX, 23'h7F_FFFF}, 5'd0);
        send_word(CMD_FLT2FIX, {1'b0, 8'd142, 23'h00_0000}, 5'd0);
        send_word(CMD_FLT2FIX, 32'h7F80_0000, 5'd0);
        send_word(CMD_FLT2FIX, 32'hFF80_0000, 5'd0);
        send_word(CMD_FLT2FIX, 32'h7FC0_0000, 5'd31);
        send_word(CMD_FLT2FIX, 32'hFFFF_FFFF, 5'd31);
    endtask

    task automatic test_random_traffic();
        send_random(1000);
    endtask

    // back-to-back on both sides to keep the pipe full
    task automatic test_full_rate();
        no_idle = 1'b1;
        send_random(300);
        no_idle = 1'b0;
    endtask

    // let the pipe run dry mid-stream, then resume
    task automatic test_drain_and_resume();
        send_random(100);
        s_tvalid <= 1'b0;
        while (expected_conversions.size() != 0) @(posedge aclk);
        send_random(100);
    endtask

    // ------------------------------------------------------------------
    // result sink and checker
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 15);
    end

    always @(posedge aclk) begin
        conversion_t c;
        if (aresetn && m_tvalid && m_tready) begin
            words_checked++;
            if (m_tuser[0]) begin
                sat_seen++;
            end
            if (expected_conversions.size() == 0) begin
                note_failure($sformatf("unexpected word %h sat %b", m_tdata, m_tuser[0]));
            end else begin
                c = expected_conversions.pop_front();
                if (m_tdata !== c.word || m_tuser[0] !== c.sat) begin
                    note_failure($sformatf(
                        "cmd %0d operand %h frac %0d: expected %h sat %b, got %h sat %b",
                        c.cmd, c.operand, c.frac, c.word, c.sat, m_tdata, m_tuser[0]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        int wait_cycles;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_fixed_edges();
        test_float_edges();
        test_random_traffic();
        test_full_rate();
        test_drain_and_resume();
        s_tvalid <= 1'b0;

        // drain, then wait for any stray word
        wait_cycles = 0;
        while (expected_conversions.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (10) @(posedge aclk);
        if (expected_conversions.size() != 0) begin
            note_failure($sformatf("%0d words never came out", expected_conversions.size()));
        end

        $display("Sent %0d fixed-to-float and %0d float-to-Q16.16 words; %0d checked.",
                 fix_sent, flt_sent, words_checked);
        $display("%0d results saturated; %0d failures.", sat_seen, fail_count);
        if (fail_count == 0) begin
            $display("fixed_float32_converter_top test passed");
        end else begin
            $display("fixed_float32_converter_top test failed");
        end
        $finish;
    end

endmodule

>>> fixed_float32_converter_top.f
+incdir+hdl
hdl/fxf_pkg.sv
hdl/fxf_decode.sv
hdl/fxf_align.sv
hdl/fxf_pack.sv
hdl/fixed_float32_converter_top.sv
bench/tb_fixed_float32_converter_top.sv
